>>> src/tcch_pkg.sv
// Shared types, constants and the arctangent table of the compass heading pipeline.
`default_nettype none
package tcch_pkg;

   localparam int unsigned RAW_W     = 16;  // raw sensor and calibration words
   localparam int unsigned OFS_W     = 17;  // min + max
   localparam int unsigned MAG_W     = 18;  // offset-corrected magnetometer
   localparam int unsigned PROD_W    = 34;  // one cross-product term
   localparam int unsigned VEC_W     = 35;  // one cross-product component
   localparam int unsigned UNIT_W    = 18;  // Q2.16 unit component
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned NORM_MSB  = 29;  // largest magnitude lands in [2^29, 2^30)
   localparam int unsigned HEAD_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned ATAN_W    = 21;
   localparam int unsigned ANG_W     = 26;  // angle accumulator, 1/32768 degree
   localparam int unsigned XY_SHIFT  = 8;
   localparam int unsigned ANG_SHIFT = 8;
   localparam int          HALF_TURN  = 5898240;
   localparam int          FULL_TURN  = 11796480;
   localparam int          HEAD_MOD   = 46080;
   localparam int          ROUND_HALF = 128;

   typedef logic signed [RAW_W-1:0]  raw_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [UNIT_W-1:0] unit_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_X = 3'd0,
      CSR_MIN_Y = 3'd1,
      CSR_MIN_Z = 3'd2,
      CSR_MAX_X = 3'd3,
      CSR_MAX_Y = 3'd4,
      CSR_MAX_Z = 3'd5
   } csr_index_type;

   localparam raw_type MIN_X_RST = -16'sd463;
   localparam raw_type MIN_Y_RST = -16'sd620;
   localparam raw_type MIN_Z_RST = -16'sd621;
   localparam raw_type MAX_X_RST = 16'sd516;
   localparam raw_type MAX_Y_RST = 16'sd273;
   localparam raw_type MAX_Z_RST = 16'sd4;

   // atan(2^-i) in 1/32768 degree
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:  val = 21'd1474560;
         5'd1:  val = 21'd870484;
         5'd2:  val = 21'd459940;
         5'd3:  val = 21'd233473;
         5'd4:  val = 21'd117189;
         5'd5:  val = 21'd58652;
         5'd6:  val = 21'd29333;
         5'd7:  val = 21'd14667;
         5'd8:  val = 21'd7334;
         5'd9:  val = 21'd3667;
         5'd10: val = 21'd1833;
         5'd11: val = 21'd917;
         5'd12: val = 21'd458;
         5'd13: val = 21'd229;
         5'd14: val = 21'd115;
         5'd15: val = 21'd57;
         5'd16: val = 21'd29;
         5'd17: val = 21'd14;
         5'd18: val = 21'd7;
         5'd19: val = 21'd4;
         5'd20: val = 21'd2;
         5'd21: val = 21'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

>>> src/tcch_norm.sv
// Pipelined vector normalizer: block scaling, square root and per-lane division to Q2.16.
`default_nettype none
module tcch_norm #(
   parameter int unsigned LANES  = 3,
   parameter int unsigned SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  tcch_pkg::vec_type        in_vec [3],
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic                     out_zero,
   output tcch_pkg::unit_type       out_unit [LANES],
   output logic [SIDE_W-1:0]        out_side
);
   import tcch_pkg::*;

   localparam int unsigned UW       = NORM_MSB + 1;
   localparam int unsigned RW       = 64;
   localparam int unsigned LW       = 31;
   localparam int unsigned NW       = 48;
   localparam int unsigned QW       = FRAC_W + 1;
   localparam int unsigned SQ_STEPS = 32;
   localparam int unsigned DV_STEPS = QW;
   localparam int unsigned LEAD_W   = 6;

   typedef struct packed {
      logic [SIDE_W-1:0]          side;
      logic                       zero;
      logic [LANES-1:0]           sgn;
      logic [LANES-1:0][UW-1:0]   u;
   } carry_type;

   // stage A: magnitudes and their maximum
   logic [VEC_W-1:0] abs_in [3];
   logic [VEC_W-1:0] max01, max_in;
   logic             a_vld_ff;
   logic [VEC_W-1:0] a_abs_ff [3];
   logic [VEC_W-1:0] a_max_ff;
   logic [2:0]       a_sgn_ff;
   logic [SIDE_W-1:0] a_side_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         abs_in[k] = in_vec[k][VEC_W-1] ? VEC_W'(-in_vec[k]) : VEC_W'(in_vec[k]);
      end
      max01  = (abs_in[0] > abs_in[1]) ? abs_in[0] : abs_in[1];
      max_in = (max01 > abs_in[2]) ? max01 : abs_in[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_abs_ff  <= abs_in;
         a_max_ff  <= max_in;
         a_sgn_ff  <= {in_vec[2][VEC_W-1], in_vec[1][VEC_W-1], in_vec[0][VEC_W-1]};
         a_side_ff <= in_side;
      end
   end

   // stage B: position of the leading one
   logic [LEAD_W-1:0] lead;
   logic              b_vld_ff;
   logic [VEC_W-1:0]  b_abs_ff [3];
   logic [LEAD_W-1:0] b_lead_ff;
   logic              b_zero_ff;
   logic [2:0]        b_sgn_ff;
   logic [SIDE_W-1:0] b_side_ff;

   always_comb begin
      lead = '0;
      for (int k = 0; k < VEC_W; k++) begin
         if (a_max_ff[k]) lead = LEAD_W'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_abs_ff  <= a_abs_ff;
         b_lead_ff <= lead;
         b_zero_ff <= (a_max_ff == '0);
         b_sgn_ff  <= a_sgn_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // stage C: common shift; right shifts truncate
   logic [UW-1:0]     u_sh [3];
   logic              c_vld_ff;
   logic [UW-1:0]     c_u_ff [3];
   logic              c_zero_ff;
   logic [2:0]        c_sgn_ff;
   logic [SIDE_W-1:0] c_side_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (b_lead_ff > LEAD_W'(NORM_MSB)) begin
            u_sh[k] = UW'(b_abs_ff[k] >> (b_lead_ff - LEAD_W'(NORM_MSB)));
         end else begin
            u_sh[k] = UW'(b_abs_ff[k] << (LEAD_W'(NORM_MSB) - b_lead_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_u_ff    <= u_sh;
         c_zero_ff <= b_zero_ff;
         c_sgn_ff  <= b_sgn_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // stage D: squares
   logic [2*UW-1:0] d_sq_ff [3];
   logic            d_vld_ff;
   carry_type       d_cr_ff;
   carry_type       c_cr;

   always_comb begin
      c_cr.side = c_side_ff;
      c_cr.zero = c_zero_ff;
      for (int l = 0; l < LANES; l++) begin
         c_cr.sgn[l] = c_sgn_ff[l];
         c_cr.u[l]   = c_u_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d_sq_ff[k] <= (2*UW)'(c_u_ff[k]) * (2*UW)'(c_u_ff[k]);
         end
         d_cr_ff <= c_cr;
      end
   end

   // stage E (square-root entry 0): sum of squares, then one result bit per stage
   logic [RW-1:0] sq_n_ff   [SQ_STEPS+1];
   logic [RW-1:0] sq_r_ff   [SQ_STEPS+1];
   carry_type     sq_cr_ff  [SQ_STEPS+1];
   logic          sq_vld_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_n_ff[0]  <= RW'(d_sq_ff[0]) + RW'(d_sq_ff[1]) + RW'(d_sq_ff[2]);
         sq_r_ff[0]  <= '0;
         sq_cr_ff[0] <= d_cr_ff;
      end
   end

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - s));
      logic [RW-1:0] trial;
      assign trial = sq_r_ff[s] + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[s+1] <= sq_vld_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (sq_n_ff[s] >= trial) begin
               sq_n_ff[s+1] <= sq_n_ff[s] - trial;
               sq_r_ff[s+1] <= (sq_r_ff[s] >> 1) + BIT;
            end else begin
               sq_n_ff[s+1] <= sq_n_ff[s];
               sq_r_ff[s+1] <= sq_r_ff[s] >> 1;
            end
            sq_cr_ff[s+1] <= sq_cr_ff[s];
         end
      end
   end

   // division: entry 0 forms the rounded numerator, then one quotient bit per stage
   logic [NW-1:0] dv_rem_ff [DV_STEPS+1][LANES];
   logic [QW-1:0] dv_q_ff   [DV_STEPS+1][LANES];
   logic [LW-1:0] dv_len_ff [DV_STEPS+1];
   carry_type     dv_cr_ff  [DV_STEPS+1];
   logic          dv_vld_ff [DV_STEPS+1];
   logic [LW-1:0] len;

   assign len = sq_r_ff[SQ_STEPS][LW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            dv_rem_ff[0][l] <= (NW'(sq_cr_ff[SQ_STEPS].u[l]) << FRAC_W) + NW'(len >> 1);
            dv_q_ff[0][l]   <= '0;
         end
         dv_len_ff[0] <= len;
         dv_cr_ff[0]  <= sq_cr_ff[SQ_STEPS];
      end
   end

   for (genvar s = 0; s < DV_STEPS; s++) begin : g_div
      localparam int unsigned J = QW - 1 - s;
      logic [NW-1:0] div_t;
      assign div_t = NW'(dv_len_ff[s]) << J;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < LANES; l++) begin
               if (dv_rem_ff[s][l] >= div_t) begin
                  dv_rem_ff[s+1][l] <= dv_rem_ff[s][l] - div_t;
                  dv_q_ff[s+1][l]   <= dv_q_ff[s][l] | (QW'(1) << J);
               end else begin
                  dv_rem_ff[s+1][l] <= dv_rem_ff[s][l];
                  dv_q_ff[s+1][l]   <= dv_q_ff[s][l];
               end
            end
            dv_len_ff[s+1] <= dv_len_ff[s];
            dv_cr_ff[s+1]  <= dv_cr_ff[s];
         end
      end
   end

   // output stage: restore the sign
   unit_type          o_unit_ff [LANES];
   logic              o_vld_ff;
   logic              o_zero_ff;
   logic [SIDE_W-1:0] o_side_ff;
   unit_type          q_pos [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         q_pos[l] = signed'(UNIT_W'(dv_q_ff[DV_STEPS][l]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            o_unit_ff[l] <= dv_cr_ff[DV_STEPS].sgn[l] ? -q_pos[l] : q_pos[l];
         end
         o_zero_ff <= dv_cr_ff[DV_STEPS].zero;
         o_side_ff <= dv_cr_ff[DV_STEPS].side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
         dv_vld_ff[0] <= 1'b0;
         o_vld_ff     <= 1'b0;
      end else if (en) begin
         a_vld_ff     <= in_valid;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         sq_vld_ff[0] <= d_vld_ff;
         dv_vld_ff[0] <= sq_vld_ff[SQ_STEPS];
         o_vld_ff     <= dv_vld_ff[DV_STEPS];
      end
   end

   assign out_valid = o_vld_ff;
   assign out_zero  = o_zero_ff;
   assign out_unit  = o_unit_ff;
   assign out_side  = o_side_ff;

endmodule
`default_nettype wire

>>> src/tcch_cordic.sv
// Pipelined vectoring CORDIC: atan2 of two Q2.16 values to a heading in 1/128 degree.
`default_nettype none
module tcch_cordic #(
   parameter int unsigned STEPS  = 16,
   parameter int unsigned SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  tcch_pkg::unit_type            in_ey,
   input  tcch_pkg::unit_type            in_nx,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [tcch_pkg::HEAD_W-1:0]   out_heading,
   output logic [SIDE_W-1:0]             out_side
);
   import tcch_pkg::*;

   localparam int unsigned CW = 28;

   logic signed [CW-1:0]    x_ff    [STEPS+1];
   logic signed [CW-1:0]    y_ff    [STEPS+1];
   logic signed [ANG_W-1:0] z_ff    [STEPS+1];
   logic                    zero_ff [STEPS+1];
   logic [SIDE_W-1:0]       side_ff [STEPS+1];
   logic                    vld_ff  [STEPS+1];

   logic signed [CW-1:0] x0, y0;

   assign x0 = signed'(CW'(in_nx)) <<< XY_SHIFT;
   assign y0 = signed'(CW'(in_ey)) <<< XY_SHIFT;

   // left half-plane folds over by half a turn
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0[CW-1] ? -x0 : x0;
         y_ff[0]    <= x0[CW-1] ? -y0 : y0;
         z_ff[0]    <= x0[CW-1] ? ANG_W'(HALF_TURN) : '0;
         zero_ff[0] <= (in_nx == '0) && (in_ey == '0);
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic signed [ANG_W-1:0] STEP_ANG = signed'(ANG_W'(atan_entry(5'(s))));
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[s] >>> s;
      assign dy = x_ff[s] >>> s;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[s][CW-1]) begin
               x_ff[s+1] <= x_ff[s] + dx;
               y_ff[s+1] <= y_ff[s] - dy;
               z_ff[s+1] <= z_ff[s] + STEP_ANG;
            end else begin
               x_ff[s+1] <= x_ff[s] - dx;
               y_ff[s+1] <= y_ff[s] + dy;
               z_ff[s+1] <= z_ff[s] - STEP_ANG;
            end
            zero_ff[s+1] <= zero_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // wrap, then round to 1/128 degree
   logic [ANG_W-1:0]    w_ang_ff;
   logic                w_zero_ff;
   logic [SIDE_W-1:0]   w_side_ff;
   logic                w_vld_ff;
   logic [ANG_W-1:0]    ang_rnd;
   logic [HEAD_W:0]     head_raw;
   logic [HEAD_W-1:0]   head;
   logic [HEAD_W-1:0]   h_head_ff;
   logic [SIDE_W-1:0]   h_side_ff;
   logic                h_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         w_ang_ff  <= z_ff[STEPS][ANG_W-1] ? ANG_W'(z_ff[STEPS] + ANG_W'(FULL_TURN))
                                           : ANG_W'(z_ff[STEPS]);
         w_zero_ff <= zero_ff[STEPS];
         w_side_ff <= side_ff[STEPS];
      end
   end

   always_comb begin
      ang_rnd  = w_ang_ff + ANG_W'(ROUND_HALF);
      head_raw = (HEAD_W+1)'(ang_rnd >> ANG_SHIFT);
      if (head_raw >= (HEAD_W+1)'(HEAD_MOD)) begin
         head_raw = head_raw - (HEAD_W+1)'(HEAD_MOD);
      end
      head = w_zero_ff ? '0 : HEAD_W'(head_raw);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_head_ff <= head;
         h_side_ff <= w_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         w_vld_ff  <= 1'b0;
         h_vld_ff  <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         w_vld_ff  <= vld_ff[STEPS];
         h_vld_ff  <= w_vld_ff;
      end
   end

   assign out_valid   = h_vld_ff;
   assign out_heading = h_head_ff;
   assign out_side    = h_side_ff;

endmodule
`default_nettype wire

>>> src/tilt_compensated_compass_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
// Takes one magnetometer/accelerometer sample pair per cycle unless stalled and returns
// one heading per item, in order. Each item passes through offset removal and the East
// cross product, the East normalizer, the North cross product, the North normalizer
// (each normalizer dominated by the 32-stage square root and the 17-stage divider), the
// CORDIC and one output register. The whole pipeline holds only when a finished result
// is stalled at the output and the last stage is occupied; empty slots keep moving so
// input is still taken. Calibration bounds may be written while no item is in flight.
`default_nettype none
module tilt_compensated_compass_heading #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tcch_pkg::raw_type                 req_mag_x,
   input  tcch_pkg::raw_type                 req_mag_y,
   input  tcch_pkg::raw_type                 req_mag_z,
   input  tcch_pkg::raw_type                 req_acc_x,
   input  tcch_pkg::raw_type                 req_acc_y,
   input  tcch_pkg::raw_type                 req_acc_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tcch_pkg::HEAD_W-1:0]       rsp_heading_deg,
   output logic                              rsp_degenerate,
   input  logic                              csr_we,
   input  logic [tcch_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcch_pkg::RAW_W-1:0]        csr_wdata
);
   import tcch_pkg::*;

   localparam int unsigned SIDE_E = 3 * RAW_W;
   localparam int unsigned SIDE_N = UNIT_W + 1;

   // calibration registers
   raw_type min_ff [3];
   raw_type max_ff [3];
   logic signed [OFS_W-1:0] sum_cal [3];
   logic signed [OFS_W-1:0] off_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff[0] <= MIN_X_RST;
         min_ff[1] <= MIN_Y_RST;
         min_ff[2] <= MIN_Z_RST;
         max_ff[0] <= MAX_X_RST;
         max_ff[1] <= MAX_Y_RST;
         max_ff[2] <= MAX_Z_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_X: min_ff[0] <= signed'(csr_wdata);
            CSR_MIN_Y: min_ff[1] <= signed'(csr_wdata);
            CSR_MIN_Z: min_ff[2] <= signed'(csr_wdata);
            CSR_MAX_X: max_ff[0] <= signed'(csr_wdata);
            CSR_MAX_Y: max_ff[1] <= signed'(csr_wdata);
            CSR_MAX_Z: max_ff[2] <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // (min + max) / 2 toward zero; used one stage after capture, so a write just
   // before an item is already seen
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_cal[k] = OFS_W'(min_ff[k]) + OFS_W'(max_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         off_ff[k] <= (sum_cal[k] + signed'(OFS_W'(sum_cal[k][OFS_W-1]))) >>> 1;
      end
   end

   logic en;
   logic cd_valid;
   logic rsp_load;

   assign rsp_load  = !(rsp_valid && rsp_stall);
   assign en        = rsp_load || !cd_valid;
   assign req_stall = !en;

   // t0: capture
   logic    t0_vld_ff;
   raw_type t0_mag_ff [3];
   raw_type t0_acc_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         t0_mag_ff[0] <= req_mag_x;
         t0_mag_ff[1] <= req_mag_y;
         t0_mag_ff[2] <= req_mag_z;
         t0_acc_ff[0] <= req_acc_x;
         t0_acc_ff[1] <= req_acc_y;
         t0_acc_ff[2] <= req_acc_z;
      end
   end

   // t1: hard-iron correction at full width
   logic                    t1_vld_ff;
   logic signed [MAG_W-1:0] t1_m_ff [3];
   raw_type                 t1_acc_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            t1_m_ff[k] <= MAG_W'(t0_mag_ff[k]) - MAG_W'(off_ff[k]);
         end
         t1_acc_ff <= t0_acc_ff;
      end
   end

   // t2: East = m x a, product terms
   logic                     t2_vld_ff;
   logic signed [PROD_W-1:0] t2_p_ff [6];
   raw_type                  t2_acc_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         t2_p_ff[0] <= PROD_W'(t1_m_ff[1]) * PROD_W'(t1_acc_ff[2]);
         t2_p_ff[1] <= PROD_W'(t1_m_ff[2]) * PROD_W'(t1_acc_ff[1]);
         t2_p_ff[2] <= PROD_W'(t1_m_ff[2]) * PROD_W'(t1_acc_ff[0]);
         t2_p_ff[3] <= PROD_W'(t1_m_ff[0]) * PROD_W'(t1_acc_ff[2]);
         t2_p_ff[4] <= PROD_W'(t1_m_ff[0]) * PROD_W'(t1_acc_ff[1]);
         t2_p_ff[5] <= PROD_W'(t1_m_ff[1]) * PROD_W'(t1_acc_ff[0]);
         t2_acc_ff  <= t1_acc_ff;
      end
   end

   // t3: East components
   logic    t3_vld_ff;
   vec_type t3_e_ff [3];
   raw_type t3_acc_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            t3_e_ff[k] <= VEC_W'(t2_p_ff[2*k]) - VEC_W'(t2_p_ff[2*k+1]);
         end
         t3_acc_ff <= t2_acc_ff;
      end
   end

   logic              ne_valid, ne_zero;
   unit_type          ne_unit [3];
   logic [SIDE_E-1:0] ne_side;

   tcch_norm #(
      .LANES  (3),
      .SIDE_W (SIDE_E)
   ) u_norm_east (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t3_vld_ff),
      .in_vec    (t3_e_ff),
      .in_side   ({t3_acc_ff[2], t3_acc_ff[1], t3_acc_ff[0]}),
      .out_valid (ne_valid),
      .out_zero  (ne_zero),
      .out_unit  (ne_unit),
      .out_side  (ne_side)
   );

   raw_type ea [3];

   assign ea[0] = signed'(ne_side[RAW_W-1:0]);
   assign ea[1] = signed'(ne_side[2*RAW_W-1:RAW_W]);
   assign ea[2] = signed'(ne_side[3*RAW_W-1:2*RAW_W]);

   // t4: North = a x East, product terms
   logic                     t4_vld_ff;
   logic signed [PROD_W-1:0] t4_p_ff [6];
   unit_type                 t4_ex_ff;
   logic                     t4_deg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t4_p_ff[0] <= PROD_W'(ea[1]) * PROD_W'(ne_unit[2]);
         t4_p_ff[1] <= PROD_W'(ea[2]) * PROD_W'(ne_unit[1]);
         t4_p_ff[2] <= PROD_W'(ea[2]) * PROD_W'(ne_unit[0]);
         t4_p_ff[3] <= PROD_W'(ea[0]) * PROD_W'(ne_unit[2]);
         t4_p_ff[4] <= PROD_W'(ea[0]) * PROD_W'(ne_unit[1]);
         t4_p_ff[5] <= PROD_W'(ea[1]) * PROD_W'(ne_unit[0]);
         t4_ex_ff   <= ne_unit[0];
         t4_deg_ff  <= ne_zero;
      end
   end

   // t5: North components
   logic     t5_vld_ff;
   vec_type  t5_n_ff [3];
   unit_type t5_ex_ff;
   logic     t5_deg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            t5_n_ff[k] <= VEC_W'(t4_p_ff[2*k]) - VEC_W'(t4_p_ff[2*k+1]);
         end
         t5_ex_ff  <= t4_ex_ff;
         t5_deg_ff <= t4_deg_ff;
      end
   end

   logic              nn_valid, nn_zero;
   unit_type          nn_unit [1];
   logic [SIDE_N-1:0] nn_side;

   // only North.x is needed past this point
   tcch_norm #(
      .LANES  (1),
      .SIDE_W (SIDE_N)
   ) u_norm_north (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t5_vld_ff),
      .in_vec    (t5_n_ff),
      .in_side   ({t5_deg_ff, t5_ex_ff}),
      .out_valid (nn_valid),
      .out_zero  (nn_zero),
      .out_unit  (nn_unit),
      .out_side  (nn_side)
   );

   logic [HEAD_W-1:0] cd_heading;
   logic              cd_deg;

   tcch_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (1)
   ) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (nn_valid),
      .in_ey       (signed'(nn_side[UNIT_W-1:0])),
      .in_nx       (nn_unit[0]),
      .in_side     (nn_side[UNIT_W] | nn_zero),
      .out_valid   (cd_valid),
      .out_heading (cd_heading),
      .out_side    (cd_deg)
   );

   // output register
   logic              rsp_valid_ff;
   logic [HEAD_W-1:0] rsp_heading_ff;
   logic              rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_heading_ff <= cd_deg ? '0 : cd_heading;
         rsp_deg_ff     <= cd_deg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff <= 1'b0;
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
         t4_vld_ff <= 1'b0;
         t5_vld_ff <= 1'b0;
      end else if (en) begin
         t0_vld_ff <= req_valid;
         t1_vld_ff <= t0_vld_ff;
         t2_vld_ff <= t1_vld_ff;
         t3_vld_ff <= t2_vld_ff;
         t4_vld_ff <= ne_valid;
         t5_vld_ff <= t4_vld_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_deg = rsp_heading_ff;
   assign rsp_degenerate  = rsp_deg_ff;

endmodule
`default_nettype wire

>>> src/tcch_checker.sv
// Port-level checks on the compass heading block and their binding to the top level.
`default_nettype none
module tcch_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [tcch_pkg::HEAD_W-1:0]   rsp_heading_deg,
   input logic                          rsp_degenerate
);
   import tcch_pkg::*;

   // a held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_heading_deg)
                                 && $stable(rsp_degenerate))
      else $error("stalled result changed");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_heading_deg == '0)
      else $error("degenerate item with nonzero heading");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading_deg < HEAD_W'(HEAD_MOD))
      else $error("heading out of range");

   // input backs up only behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_heading_deg (rsp_heading_deg),
   .rsp_degenerate  (rsp_degenerate)
);
`default_nettype wire

>>> dv/tb_tilt_compensated_compass_heading.sv
// Self-checking testbench for the tilt-compensated compass heading pipeline.
`default_nettype none
module tb_tilt_compensated_compass_heading;
   timeunit 1ns;
   timeprecision 1ps;
   import tcch_pkg::*;

   localparam int LATENCY = 138;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int N_RANDOM = 830;

   typedef struct {
      raw_type mx, my, mz, ax, ay, az;
   } sample_type;

   typedef struct {
      logic [HEAD_W-1:0] heading;
      logic degen;
   } heading_type;

   typedef struct {
      sample_type s;
      logic       known;
      heading_type exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   raw_type req_mag_x = '0, req_mag_y = '0, req_mag_z = '0;
   raw_type req_acc_x = '0, req_acc_y = '0, req_acc_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [HEAD_W-1:0] rsp_heading_deg;
   logic rsp_degenerate;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RAW_W-1:0] csr_wdata = '0;

   tilt_compensated_compass_heading dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // calibration copy kept by the predictor
   longint cal_lo[3], cal_hi[3];
   heading_type headings_due[$];
   int errors = 0;
   longint cycles = 0;
   bit calm = 0;  // no idling on either side while set

   localparam longint ATAN_TBL[24] = '{1474560, 870484, 459940, 233473, 117189, 58652,
      29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic bit to_unit(input longint v[3], output longint q[3]);
      longint unsigned u[3], m = 0, s = 0, len;
      int rs = 0, ls = 0;
      for (int k = 0; k < 3; k++) begin
         u[k] = v[k] < 0 ? -v[k] : v[k];
         if (u[k] > m) m = u[k];
      end
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin m >>= 1; rs++; end
      while (m < (64'd1 << 29)) begin m <<= 1; ls++; end
      for (int k = 0; k < 3; k++) begin
         u[k] = (u[k] >> rs) << ls;
         s += u[k] * u[k];
      end
      len = root_floor(s);
      for (int k = 0; k < 3; k++) begin
         longint mg;
         mg = ((u[k] << 16) + (len >> 1)) / len;
         q[k] = v[k] < 0 ? -mg : mg;
      end
      return 1;
   endfunction

   function automatic longint cordic_angle(longint ey, longint nx);
      longint x = nx * 256, y = ey * 256, z = 0, dx, dy, h;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x; y = -y; z = HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_TBL[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_TBL[i];
         end
      end
      if (z < 0) z += FULL_TURN;
      h = (z + 128) >>> 8;
      if (h >= HEAD_MOD) h -= HEAD_MOD;
      return h;
   endfunction

   function automatic heading_type predict_heading(sample_type s);
      heading_type r;
      longint m[3], a[3], e[3], eq[3], n[3], nq[3];
      longint raw[3];
      raw = '{s.mx, s.my, s.mz};
      a = '{s.ax, s.ay, s.az};
      for (int k = 0; k < 3; k++) begin
         longint sum;
         sum = cal_lo[k] + cal_hi[k];
         m[k] = raw[k] - (sum < 0 ? -((-sum) / 2) : sum / 2);
      end
      e[0] = m[1] * a[2] - m[2] * a[1];
      e[1] = m[2] * a[0] - m[0] * a[2];
      e[2] = m[0] * a[1] - m[1] * a[0];
      r.heading = '0;
      r.degen = 1'b1;
      if (!to_unit(e, eq)) return r;
      n[0] = a[1] * eq[2] - a[2] * eq[1];
      n[1] = a[2] * eq[0] - a[0] * eq[2];
      n[2] = a[0] * eq[1] - a[1] * eq[0];
      if (!to_unit(n, nq)) return r;
      r.heading = HEAD_W'(cordic_angle(eq[0], nq[0]));
      r.degen = 1'b0;
      return r;
   endfunction

   // result side: random stall, checks at the rising edge
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (headings_due.size() == 0) begin
            $error("unexpected item: heading_deg %0d", rsp_heading_deg);
            errors++;
         end else begin
            heading_type e;
            e = headings_due.pop_front();
            if (rsp_heading_deg !== e.heading) begin
               $error("heading_deg expected %0d actual %0d", e.heading, rsp_heading_deg);
               errors++;
            end
            if (rsp_degenerate !== e.degen) begin
               $error("degenerate expected %0d actual %0d", e.degen, rsp_degenerate);
               errors++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 36);

   task automatic write_cal(csr_index_type idx, raw_type val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MIN_X: cal_lo[0] = val;
         CSR_MIN_Y: cal_lo[1] = val;
         CSR_MIN_Z: cal_lo[2] = val;
         CSR_MAX_X: cal_hi[0] = val;
         CSR_MAX_Y: cal_hi[1] = val;
         default:   cal_hi[2] = val;
      endcase
   endtask

   task automatic set_cal(raw_type lx, raw_type ly, raw_type lz,
                          raw_type hx, raw_type hy, raw_type hz);
      write_cal(CSR_MIN_X, lx); write_cal(CSR_MIN_Y, ly); write_cal(CSR_MIN_Z, lz);
      write_cal(CSR_MAX_X, hx); write_cal(CSR_MAX_Y, hy); write_cal(CSR_MAX_Z, hz);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (headings_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
   endtask

   // drive one item from the falling edge; returns at the falling edge after acceptance,
   // leaving valid high until the next item or a drain takes it down
   task automatic send_item(sample_type s, bit known, heading_type want);
      heading_type p;
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mag_x <= s.mx; req_mag_y <= s.my; req_mag_z <= s.mz;
      req_acc_x <= s.ax; req_acc_y <= s.ay; req_acc_z <= s.az;
      p = predict_heading(s);
      if (known && (p.heading !== want.heading || p.degen !== want.degen)) begin
         $error("table row disagrees: heading_deg expected %0d actual %0d",
                want.heading, p.heading);
         errors++;
      end
      do @(posedge clock); while (req_stall);
      headings_due.push_back(known ? want : p);
      @(negedge clock);
   endtask

   function automatic raw_type rnd_raw();
      case ($urandom_range(5))
         0: return raw_type'(16'h8000 + $urandom_range(3));
         1: return raw_type'(16'h7FFF - $urandom_range(3));
         2: return raw_type'($urandom_range(8) - 4);
         3: return raw_type'($urandom_range(4000) - 2000);
         default: return raw_type'($urandom);
      endcase
   endfunction

   row_type dir_rows[$];

   initial begin
      sample_type s;
      heading_type none;
      none = '{heading: '0, degen: 1'b0};
      cal_lo = '{MIN_X_RST, MIN_Y_RST, MIN_Z_RST};
      cal_hi = '{MAX_X_RST, MAX_Y_RST, MAX_Z_RST};
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      calm = 1;

      // directed rows: all-zero and parallel vectors give the degenerate flag
      dir_rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 1}});
      dir_rows.push_back('{'{100, 200, 300, 0, 0, 0}, 1, '{0, 1}});
      dir_rows.push_back('{'{24, -173, -308, 0, 0, 0}, 1, '{0, 1}});
      dir_rows.push_back('{'{1000, 0, 0, 0, 0, 16384}, 0, none});
      dir_rows.push_back('{'{0, 1000, 0, 0, 0, 16384}, 0, none});
      dir_rows.push_back('{'{-1000, 0, 0, 0, 0, 16384}, 0, none});
      dir_rows.push_back('{'{0, -1000, 0, 0, 0, -16384}, 0, none});
      dir_rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767}, 0, none});
      dir_rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768}, 0, none});
      dir_rows.push_back('{'{32767, -32768, 32767, -32768, 32767, -32768}, 0, none});
      dir_rows.push_back('{'{-32768, 32767, 0, 0, 0, 32767}, 0, none});
      dir_rows.push_back('{'{5, 700, -9, 1, -1, 1}, 0, none});
      dir_rows.push_back('{'{0, 0, 5000, 0, 16384, 0}, 0, none});
      dir_rows.push_back('{'{0, 0, 5000, 16384, 0, 0}, 0, none});
      foreach (dir_rows[i]) send_item(dir_rows[i].s, dir_rows[i].known, dir_rows[i].exp);
      drain();

      // extreme calibration, with min equal to max
      set_cal(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      calm = 0;
      for (int i = 0; i < 6; i++) begin
         s = '{rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw()};
         send_item(s, 0, none);
      end
      drain();
      set_cal(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      for (int i = 0; i < 6; i++) begin
         s = '{rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw()};
         send_item(s, 0, none);
      end
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         set_cal(rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw());
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            calm = (ph == 1 && i < 120);
            s = '{rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw(), rnd_raw()};
            send_item(s, 0, none);
            if (ph == 2 && i == 50) begin
               req_valid <= 1'b0;
               while (headings_due.size() != 0) @(negedge clock);
            end
         end
         calm = 0;
         drain();
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
src/tcch_pkg.sv
src/tcch_norm.sv
src/tcch_cordic.sv
src/tilt_compensated_compass_heading.sv
src/tcch_checker.sv
dv/tb_tilt_compensated_compass_heading.sv
